[src/wfd_pkg.sv]
// wfd_pkg: shared types, constants and helper functions of the 2-D wave solver
// used by wfd_ctrl, wfd_datapath and the top level wave_fdtd_2d_neumann
// no dependencies
package wfd_pkg;

  localparam int COLS_MAX  = 64;
  localparam int ROWS_MAX  = 64;
  localparam int SAMPLE_W  = 32;
  localparam int FRAC_BITS = SAMPLE_W - 5;
  localparam int CELLS     = COLS_MAX * ROWS_MAX;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int COL_W     = $clog2(COLS_MAX);
  localparam int ROW_W     = $clog2(ROWS_MAX);
  localparam int SIZE_W    = 7;
  localparam int WEIGHT_W  = 17;
  localparam int CNT_W     = 13;
  localparam int EDGE_W    = 7;

  // stencil sweep: one read per cell plus one column of look-ahead, then pipeline drain
  localparam int SWEEP_LEN  = CELLS + ROWS_MAX;
  localparam int SWEEP_LAST = SWEEP_LEN + 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
  localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = SAMPLE_W'(1) << FRAC_BITS;
  localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_ONE = ~SAMPLE_ONE + SAMPLE_W'(1);

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } op_t;

  localparam logic [1:0] CFG_COLS   = 2'd0;
  localparam logic [1:0] CFG_ROWS   = 2'd1;
  localparam logic [1:0] CFG_WEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_ROTATE,
    ST_CELL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              clear;
    logic              impulse;
    logic              steps_clr;
    logic [CNT_W-1:0]  addr;
    logic              sweep;
    logic              edge_wr;
    logic              edge_row;
    logic [EDGE_W-1:0] edge_idx;
    logic              rotate;
    logic              cell_sel;
  } wfd_cmd_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_W'(4)) r = SIZE_W'(4);
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [WEIGHT_W-1:0] v);
    return (v > WEIGHT_ONE) ? WEIGHT_ONE : v;
  endfunction

endpackage

[src/wfd_ctrl.sv]
// wfd_ctrl: sequencer for clear, stencil sweep, wall copy, grid rotation and reads
// depends on wfd_pkg
module wfd_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [wfd_pkg::SIZE_W-1:0] cols,
  input  logic [wfd_pkg::SIZE_W-1:0] rows,
  input  logic                      out_free,
  output logic                      load_out,
  output wfd_pkg::wfd_cmd_t         cmd
);
  import wfd_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             edge_row, edge_row_next;
  logic             item_busy;
  logic [7:0]       edge_last;
  logic             in_fire;

  assign in_fire   = in_valid && in_ready;
  assign edge_last = edge_row ? ({1'b0, cols} << 1) - 8'd1 : ({1'b0, rows} << 1) - 8'd1;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    edge_row_next = edge_row;
    case (state)
      ST_CLEAR: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(CELLS - 1)) begin
          state_next = item_busy ? ST_DONE : ST_IDLE;
          cnt_next   = '0;
        end
      end
      ST_IDLE: begin
        cnt_next = '0;
        if (in_fire) begin
          case (op)
            OP_INIT: state_next = ST_CLEAR;
            OP_STEP: state_next = ST_SWEEP;
            OP_READ: state_next = ST_CELL;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(SWEEP_LAST)) begin
          state_next    = ST_EDGE_RD;
          cnt_next      = '0;
          edge_row_next = 1'b0;
        end
      end
      ST_EDGE_RD: state_next = ST_EDGE_WR;
      ST_EDGE_WR: begin
        state_next = ST_EDGE_RD;
        cnt_next   = cnt + CNT_W'(1);
        if ({1'b0, cnt[EDGE_W-1:0]} == edge_last) begin
          cnt_next = '0;
          if (edge_row) state_next = ST_ROTATE;
          else edge_row_next = 1'b1;
        end
      end
      ST_ROTATE: state_next = ST_DONE;
      ST_CELL:   state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == ST_IDLE);
    load_out      = (state == ST_DONE) && out_free;
    cmd.clear     = (state == ST_CLEAR);
    cmd.impulse   = item_busy;
    cmd.steps_clr = (state == ST_CLEAR) && item_busy;
    cmd.addr      = cnt;
    cmd.sweep     = (state == ST_SWEEP);
    cmd.edge_wr   = (state == ST_EDGE_WR);
    cmd.edge_row  = edge_row;
    cmd.edge_idx  = cnt[EDGE_W-1:0];
    cmd.rotate    = (state == ST_ROTATE);
    cmd.cell_sel  = (op == OP_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      edge_row  <= 1'b0;
      item_busy <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      edge_row <= edge_row_next;
      if (in_fire) item_busy <= 1'b1;
      else if (load_out) item_busy <= 1'b0;
    end
  end

  a_load_busy: assert property (@(posedge clk) disable iff (rst) load_out |-> item_busy)
    else $error("result loaded with no item in flight");
  a_fire_blocks: assert property (@(posedge clk) disable iff (rst) in_fire |=> !in_ready)
    else $error("second item taken while first in progress");
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (cnt <= CNT_W'(SWEEP_LAST)))
    else $error("sweep counter overran");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) load_out |=> in_ready)
    else $error("not idle after result");

endmodule

[src/wfd_datapath.sv]
// wfd_datapath: three grid memories with rotating roles, stencil line buffer,
// weighted update pipeline, wall copy addressing and the step counter; depends on wfd_pkg
module wfd_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  wfd_pkg::wfd_cmd_t           cmd,
  input  logic [wfd_pkg::SIZE_W-1:0]   cols,
  input  logic [wfd_pkg::SIZE_W-1:0]   rows,
  input  logic [wfd_pkg::WEIGHT_W-1:0] weight,
  input  logic [wfd_pkg::COL_W-1:0]    cell_col,
  input  logic [wfd_pkg::ROW_W-1:0]    cell_row,
  output logic [wfd_pkg::SAMPLE_W-1:0] cell_value,
  output logic [31:0]                 steps_done
);
  import wfd_pkg::*;

  logic [1:0] prev_sel, now_sel, next_sel;

  logic [2:0]          bank_we;
  logic [ADDR_W-1:0]   bank_waddr [3];
  logic [SAMPLE_W-1:0] bank_wdata [3];
  logic [ADDR_W-1:0]   bank_raddr [3];
  logic [SAMPLE_W-1:0] bank_rdata [3];

  logic [SAMPLE_W-1:0] rd_now, rd_prev, rd_next;
  assign rd_now  = bank_rdata[now_sel];
  assign rd_prev = bank_rdata[prev_sel];
  assign rd_next = bank_rdata[next_sel];

  // stencil line: sh[j] holds the now sample read j+1 reads before rd_now
  logic [SAMPLE_W-1:0] sh [2*ROWS_MAX];

  logic              v0, v1, v2, v3;
  // set by init until the first rotation: cells outside the active region step to zero
  logic              fresh;
  logic [CNT_W-1:0]  a1;
  logic [ADDR_W-1:0] p1, p2, p3;
  logic              int2, int3;
  logic [SAMPLE_W-1:0] ctr2, ctr3;
  logic signed [34:0]  d2;
  logic signed [33:0]  base2, base3;
  logic signed [52:0]  prod3;

  // stage 1 combinational
  logic [SAMPLE_W-1:0] s_ctr, s_left, s_right, s_top, s_bot;
  logic signed [33:0]  nbr_sum, base1;
  logic signed [34:0]  d1, ctr35;
  logic [COL_W-1:0]    c1;
  logic [ROW_W-1:0]    r1;
  logic                in1, out1;

  always_comb begin
    s_ctr   = sh[ROWS_MAX-1];
    s_left  = sh[2*ROWS_MAX-1];
    s_right = rd_now;
    s_bot   = sh[ROWS_MAX-2];
    s_top   = sh[ROWS_MAX];
    nbr_sum = $signed({{2{s_left[31]}}, s_left}) + $signed({{2{s_right[31]}}, s_right})
            + $signed({{2{s_top[31]}}, s_top}) + $signed({{2{s_bot[31]}}, s_bot});
    ctr35   = $signed({{3{s_ctr[31]}}, s_ctr});
    d1      = $signed({nbr_sum[33], nbr_sum}) - (ctr35 <<< 2);
    base1   = ($signed({{2{s_ctr[31]}}, s_ctr}) <<< 1) - $signed({{2{rd_prev[31]}}, rd_prev});
    p1      = ADDR_W'(a1 - CNT_W'(ROWS_MAX));
    c1      = p1[ADDR_W-1:ROW_W];
    r1      = p1[ROW_W-1:0];
    in1     = (c1 != '0) && ({1'b0, c1} < cols - SIZE_W'(1))
           && (r1 != '0) && ({1'b0, r1} < rows - SIZE_W'(1));
    out1    = ({1'b0, c1} >= cols) || ({1'b0, r1} >= rows);
  end

  // stage 3 combinational: round, add and saturate
  logic signed [52:0] rnd;
  logic signed [37:0] vsum;
  logic [SAMPLE_W-1:0] s3_val;
  always_comb begin
    rnd  = prod3 + 53'sd32768;
    vsum = $signed({{4{base3[33]}}, base3}) + $signed({rnd[52], rnd[52:16]});
    if (vsum > 38'sd2147483647) s3_val = 32'h7FFF_FFFF;
    else if (vsum < -38'sd2147483648) s3_val = 32'h8000_0000;
    else s3_val = vsum[SAMPLE_W-1:0];
  end

  // wall copy and impulse addresses
  logic [COL_W-1:0]  e_pos;
  logic              e_side;
  logic [SIZE_W-1:0] cols_m1, cols_m2, rows_m1, rows_m2, imp_c1, imp_c2, imp_r;
  logic [ADDR_W-1:0] e_src, e_dst, imp_a1, imp_a2, cell_addr;

  always_comb begin
    e_pos   = cmd.edge_idx[EDGE_W-1:1];
    e_side  = cmd.edge_idx[0];
    cols_m1 = cols - SIZE_W'(1);
    cols_m2 = cols - SIZE_W'(2);
    rows_m1 = rows - SIZE_W'(1);
    rows_m2 = rows - SIZE_W'(2);
    if (!cmd.edge_row) begin
      e_dst = {(e_side ? cols_m1[COL_W-1:0] : COL_W'(0)), e_pos};
      e_src = {(e_side ? cols_m2[COL_W-1:0] : COL_W'(1)), e_pos};
    end else begin
      e_dst = {e_pos, (e_side ? rows_m1[ROW_W-1:0] : ROW_W'(0))};
      e_src = {e_pos, (e_side ? rows_m2[ROW_W-1:0] : ROW_W'(1))};
    end
    imp_c1    = cols >> 2;
    imp_c2    = imp_c1 + (imp_c1 << 1);
    imp_r     = rows >> 2;
    imp_a1    = {imp_c1[COL_W-1:0], imp_r[ROW_W-1:0]};
    imp_a2    = {imp_c2[COL_W-1:0], imp_r[ROW_W-1:0]};
    cell_addr = {cell_col, cell_row};
    v0        = cmd.sweep && (cmd.addr < CNT_W'(SWEEP_LEN));
  end

  // bank port steering by role
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      bank_we[b]    = 1'b0;
      bank_waddr[b] = cmd.addr[ADDR_W-1:0];
      bank_wdata[b] = '0;
      bank_raddr[b] = e_src;
      if (cmd.clear) begin
        bank_we[b] = 1'b1;
        if (cmd.impulse && (2'(b) == now_sel)) begin
          if (cmd.addr[ADDR_W-1:0] == imp_a1) bank_wdata[b] = SAMPLE_ONE;
          else if (cmd.addr[ADDR_W-1:0] == imp_a2) bank_wdata[b] = SAMPLE_NEG_ONE;
        end
      end else if (2'(b) == next_sel) begin
        if (v3) begin
          bank_we[b]    = 1'b1;
          bank_waddr[b] = p3;
          bank_wdata[b] = int3 ? s3_val : ctr3;
        end else if (cmd.edge_wr) begin
          bank_we[b]    = 1'b1;
          bank_waddr[b] = e_dst;
          bank_wdata[b] = rd_next;
        end
      end
      if (2'(b) == now_sel) bank_raddr[b] = cmd.sweep ? cmd.addr[ADDR_W-1:0] : cell_addr;
      else if (2'(b) == prev_sel) bank_raddr[b] = ADDR_W'(cmd.addr - CNT_W'(ROWS_MAX));
    end
  end

  for (genvar gb = 0; gb < 3; gb++) begin : g_bank
    logic [SAMPLE_W-1:0] mem [CELLS];
    always_ff @(posedge clk) begin
      if (bank_we[gb]) mem[bank_waddr[gb]] <= bank_wdata[gb];
      bank_rdata[gb] <= mem[bank_raddr[gb]];
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      sh[0] <= rd_now;
      for (int j = 1; j < 2*ROWS_MAX; j++) sh[j] <= sh[j-1];
    end
    a1    <= cmd.addr;
    p2    <= p1;
    int2  <= in1;
    ctr2  <= (out1 && fresh) ? '0 : s_ctr;
    d2    <= d1;
    base2 <= base1;
    p3    <= p2;
    int3  <= int2;
    ctr3  <= ctr2;
    base3 <= base2;
    prod3 <= $signed({1'b0, weight}) * d2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      fresh      <= 1'b0;
      prev_sel   <= 2'd0;
      now_sel    <= 2'd1;
      next_sel   <= 2'd2;
      steps_done <= '0;
    end else begin
      v1 <= v0;
      v2 <= v1 && (a1 >= CNT_W'(ROWS_MAX));
      v3 <= v2;
      if (cmd.steps_clr) begin
        steps_done <= '0;
        fresh      <= 1'b1;
      end
      if (cmd.rotate) begin
        prev_sel   <= now_sel;
        now_sel    <= next_sel;
        next_sel   <= prev_sel;
        fresh      <= 1'b0;
        steps_done <= steps_done + 32'd1;
      end
    end
  end

  assign cell_value = (cmd.cell_sel && ({1'b0, cell_col} < cols) && ({1'b0, cell_row} < rows))
                      ? rd_now : '0;

endmodule

[src/wave_fdtd_2d_neumann.sv]
// wave_fdtd_2d_neumann: top level of the 2-D acoustic wave solver with rigid walls
// depends on wfd_pkg, wfd_ctrl and wfd_datapath
module wave_fdtd_2d_neumann (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // op[1:0], col_index[7:2], row_index[13:8], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // cell_value[31:0], steps_done[63:32]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  // Solves the 2-D wave equation on up to 64x64 cells with a five-point stencil,
  // holding previous, current and next pressure grids (signed Q4.27) in three
  // 4096-word memories whose roles rotate after each step. Every input transfer
  // (op 0 init, 1 step, 2 read cell) gives exactly one output transfer carrying
  // the addressed current cell (zero unless a read inside the active grid) and
  // the step count. Items run one at a time: an init clears one memory word per
  // cycle, a step runs the stencil sweep, which reads one cell of the current
  // grid per cycle through a 128-sample line buffer, then the wall copy, which
  // moves each edge cell by a read and a write through the next-grid port. After
  // reset a clearing pass over all 4096 memory words runs before the first
  // transfer is taken. The user must write configuration only while no item is
  // in flight; the block itself does not enforce this.
  import wfd_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0]   cfg_cols, cfg_rows;
  logic [WEIGHT_W-1:0] cfg_weight;
  logic [SIZE_W-1:0]   cols, rows;
  logic [WEIGHT_W-1:0] weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols   <= SIZE_W'(COLS_MAX);
      cfg_rows   <= SIZE_W'(ROWS_MAX);
      cfg_weight <= WEIGHT_W'(32768);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COLS:   cfg_cols   <= cfg_wdata[SIZE_W-1:0];
        CFG_ROWS:   cfg_rows   <= cfg_wdata[SIZE_W-1:0];
        CFG_WEIGHT: cfg_weight <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // effective sizes and weight, out-of-range values pinned to their limits
  assign cols   = clamp_size(cfg_cols, SIZE_W'(COLS_MAX));
  assign rows   = clamp_size(cfg_rows, SIZE_W'(ROWS_MAX));
  assign weight = clamp_weight(cfg_weight);

  // item register, loaded on an input transfer
  logic [1:0]       op;
  logic [1:0]       op_sel;
  logic [COL_W-1:0] cell_col;
  logic [ROW_W-1:0] cell_row;
  logic             in_fire;

  assign in_fire = s_tvalid && s_tready;

  // op of the item being taken, else the held one
  assign op_sel = in_fire ? s_tdata[1:0] : op;

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_STEP;
    end else if (in_fire) begin
      op <= s_tdata[1:0];
    end
    if (in_fire) begin
      cell_col <= s_tdata[7:2];
      cell_row <= s_tdata[13:8];
    end
  end

  wfd_cmd_t            cmd;
  logic                load_out, out_free;
  logic [SAMPLE_W-1:0] cell_value;
  logic [31:0]         steps_done;

  // output register: a finished result waits here while the next item may enter
  assign out_free = !m_tvalid || m_tready;

  wfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .op       (op_sel),
    .cols     (cols),
    .rows     (rows),
    .out_free (out_free),
    .load_out (load_out),
    .cmd      (cmd)
  );

  wfd_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cols       (cols),
    .rows       (rows),
    .weight     (weight),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .cell_value (cell_value),
    .steps_done (steps_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_out) m_tdata <= {steps_done, cell_value};
  end

endmodule
